[hdl/hts_pkg.sv]
`timescale 1ns / 1ps
// hts_pkg: shared types and constants of the terrain height sampler
// used by heightfield_triangle_sample_unit, both checkers and the testbench; no dependencies

package hts_pkg;

	// default depth of the height store
	localparam int MAX_VERTICES_DEF = 65536;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COLS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_ROWS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd6;

	// register reset values
	localparam logic [8:0]  RST_VERTEX_COLS = 9'd256;
	localparam logic [8:0]  RST_VERTEX_ROWS = 9'd256;
	localparam logic [15:0] RST_CELL_SIZE   = 16'd256;
	localparam logic [23:0] RST_HALF_WIDTH  = 24'd8355840;
	localparam logic [23:0] RST_HALF_HEIGHT = 24'd8355840;
	localparam logic [15:0] RST_SCALE_Y     = 16'd256;
	localparam logic [23:0] RST_OFFSET_Y    = 24'd0;

	// item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// cell coordinate is Q9.16, one quotient bit per divider stage
	localparam int COORD_W  = 25;
	localparam int DIV_STEPS = COORD_W;
	// widest corner address before reduction
	localparam int LIN_W = 18;

	// one lane of the restoring divider
	typedef struct packed {
		logic [15:0]        rem;
		logic [COORD_W-1:0] low;
		logic [COORD_W-1:0] quo;
		logic               neg;
		logic               sat;
	} hts_dv_t;

	// what an item carries besides its coordinates
	typedef struct packed {
		logic        kind;
		logic [15:0] idx;
		logic [7:0]  val;
	} hts_item_t;

endpackage

[hdl/heightfield_triangle_sample_unit.sv]
`timescale 1ns / 1ps
// heightfield_triangle_sample_unit: terrain height sampler, top level
// depends on hts_pkg; holds the height store, the divider pipeline and the interpolator

// A load beat writes one 8-bit height into the store and gives no result; a
// query beat gives one signed Q24.8 height. Every beat enters a pipeline:
// input stage, a 25-stage restoring divider per axis (one quotient bit each),
// clamp, base address, corner addresses, modulo reduction, then the memory
// stage in front of the single-port height store. That port sets the rate: a
// load holds it for one write, a query for four reads (one per corner), so
// loads are taken at one beat per cycle while no query holds the port and the
// output does not stall, and a query holds the beats behind it until its last
// read. Results leave through an output register; while a result waits there the
// pipeline keeps moving and keeps taking beats as long as its last stage is empty.
// Loads and queries stay in order, so a query always sees every earlier load. The
// user must write configuration only while the block is idle; it does not check.

module heightfield_triangle_sample_unit #(
	parameter int MAX_VERTICES = hts_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [15:0]                   height_index,
	input  logic [7:0]                    height_value,
	input  logic signed [23:0]            pos_x,
	input  logic signed [23:0]            pos_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            terrain_height
);
	import hts_pkg::*;

	// store address width and reciprocal for the modulo of corner addresses
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int RS = LIN_W + AW;
	localparam logic [63:0] RECIP64 = ((64'd1 << RS) / 64'(MAX_VERTICES)) + 64'd1;
	localparam logic [19:0] RECIP = RECIP64[19:0];
	localparam logic [38:0] MAXV = 39'(MAX_VERTICES);
	localparam logic [20:0] MAXV21 = 21'(MAX_VERTICES);

	// configuration registers
	logic [8:0]  vertex_cols_q, vertex_rows_q;
	logic [15:0] cell_size_q, scale_y_q;
	logic [23:0] half_width_q, half_height_q, offset_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_cols_q <= RST_VERTEX_COLS;
			vertex_rows_q <= RST_VERTEX_ROWS;
			cell_size_q   <= RST_CELL_SIZE;
			half_width_q  <= RST_HALF_WIDTH;
			half_height_q <= RST_HALF_HEIGHT;
			scale_y_q     <= RST_SCALE_Y;
			offset_y_q    <= RST_OFFSET_Y;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERTEX_COLS: vertex_cols_q <= cfg_data[8:0];
				REG_VERTEX_ROWS: vertex_rows_q <= cfg_data[8:0];
				REG_CELL_SIZE:   cell_size_q   <= cfg_data[15:0];
				REG_HALF_WIDTH:  half_width_q  <= cfg_data;
				REG_HALF_HEIGHT: half_height_q <= cfg_data;
				REG_SCALE_Y:     scale_y_q     <= cfg_data[15:0];
				REG_OFFSET_Y:    offset_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero cell size behaves as the smallest step
	logic [15:0] divisor;
	assign divisor = (cell_size_q == 16'd0) ? 16'd1 : cell_size_q;

	// --------------------------------------------------------------------
	// flow control: en_dn moves the memory stage and everything after it,
	// en_up everything in front of the memory stage
	// --------------------------------------------------------------------
	logic en_dn, en_up;
	logic vld_s6, vld_s10, out_vld_q;
	hts_item_t item_s6;
	logic [1:0] cnt_q;

	assign en_dn = !(out_vld_q && !out_ready && vld_s10);
	// a query sits in the memory stage until its fourth corner read
	assign en_up = en_dn && !(vld_s6 && (item_s6.kind == KIND_QUERY) && (cnt_q != 2'd3));
	assign in_ready = en_up;

	// --------------------------------------------------------------------
	// stage 1: numerators in Q.8 (x shifted by half width, z mirrored)
	// --------------------------------------------------------------------
	logic             vld_s1;
	hts_item_t        item_s1;
	logic signed [25:0] numx_s1, numz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en_up) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			item_s1.kind <= kind;
			item_s1.idx  <= height_index;
			item_s1.val  <= height_value;
			numx_s1 <= $signed({2'b00, half_width_q}) + 26'(pos_x);
			numz_s1 <= $signed({2'b00, half_height_q}) - 26'(pos_z);
		end
	end

	// --------------------------------------------------------------------
	// divider pipeline: (num << 16) / divisor, one quotient bit per stage;
	// quotients at or above 2^25 are flagged and clamp to the cap later
	// --------------------------------------------------------------------
	function automatic hts_dv_t div_init(input logic signed [25:0] num,
			input logic [15:0] dv);
		hts_dv_t r;
		r.neg = num[25] || (num == 26'sd0);
		r.sat = !r.neg && (num[24:0] >= {dv, 9'd0});
		r.rem = num[24:9];
		r.low = {num[8:0], 16'd0};
		r.quo = '0;
		return r;
	endfunction

	function automatic hts_dv_t div_step(input hts_dv_t a, input logic [15:0] dv);
		hts_dv_t r;
		logic [16:0] t;
		t = {a.rem, a.low[COORD_W-1]};
		r = a;
		r.low = {a.low[COORD_W-2:0], 1'b0};
		if (t >= {1'b0, dv}) begin
			r.rem = 16'(t - {1'b0, dv});
			r.quo = {a.quo[COORD_W-2:0], 1'b1};
		end else begin
			r.rem = t[15:0];
			r.quo = {a.quo[COORD_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic      dv_vld_s  [DIV_STEPS+1];
	hts_item_t dv_item_s [DIV_STEPS+1];
	hts_dv_t   dvx_s     [DIV_STEPS+1];
	hts_dv_t   dvz_s     [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld_s[0] <= 1'b0;
		else if (en_up) dv_vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			dv_item_s[0] <= item_s1;
			dvx_s[0]     <= div_init(numx_s1, divisor);
			dvz_s[0]     <= div_init(numz_s1, divisor);
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[k] <= 1'b0;
			else if (en_up) dv_vld_s[k] <= dv_vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en_up) begin
				dv_item_s[k] <= dv_item_s[k-1];
				dvx_s[k]     <= div_step(dvx_s[k-1], divisor);
				dvz_s[k]     <= div_step(dvz_s[k-1], divisor);
			end
		end
	end

	// --------------------------------------------------------------------
	// stage 2: clamp the cell coordinate to [0, (verts-2) << 16]
	// --------------------------------------------------------------------
	function automatic logic [COORD_W-1:0] clamp_coord(input hts_dv_t d,
			input logic [8:0] verts);
		logic [COORD_W-1:0] cap;
		logic [COORD_W-1:0] r;
		cap = (verts >= 9'd2) ? {9'(verts - 9'd2), 16'd0} : '0;
		if (d.neg) r = '0;
		else if (d.sat || (d.quo > cap)) r = cap;
		else r = d.quo;
		return r;
	endfunction

	logic               vld_s2;
	hts_item_t          item_s2;
	logic [COORD_W-1:0] cx_s2, cz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en_up) vld_s2 <= dv_vld_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			item_s2 <= dv_item_s[DIV_STEPS];
			cx_s2   <= clamp_coord(dvx_s[DIV_STEPS], vertex_cols_q);
			cz_s2   <= clamp_coord(dvz_s[DIV_STEPS], vertex_rows_q);
		end
	end

	// --------------------------------------------------------------------
	// stage 3: row-major base index and triangle choice
	// --------------------------------------------------------------------
	logic             vld_s3, upper_s3;
	hts_item_t        item_s3;
	logic [LIN_W-1:0] base_s3;
	logic [15:0]      u_s3, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en_up) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			item_s3  <= item_s2;
			base_s3  <= 18'(cz_s2[24:16] * vertex_cols_q) + 18'(cx_s2[24:16]);
			u_s3     <= cx_s2[15:0];
			v_s3     <= cz_s2[15:0];
			// diagonal tie stays on the lower triangle
			upper_s3 <= ({1'b0, cx_s2[15:0]} + {1'b0, cz_s2[15:0]}) > 17'h10000;
		end
	end

	// --------------------------------------------------------------------
	// stage 4: the four corner indices
	// --------------------------------------------------------------------
	logic             vld_s4, upper_s4;
	hts_item_t        item_s4;
	logic [LIN_W-1:0] lin_s4 [4];
	logic [15:0]      u_s4, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en_up) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			item_s4   <= item_s3;
			lin_s4[0] <= base_s3;
			lin_s4[1] <= base_s3 + 18'd1;
			lin_s4[2] <= base_s3 + 18'(vertex_cols_q);
			lin_s4[3] <= base_s3 + 18'(vertex_cols_q) + 18'd1;
			u_s4      <= u_s3;
			v_s4      <= v_s3;
			upper_s4  <= upper_s3;
		end
	end

	// --------------------------------------------------------------------
	// stage 5: quotient of index / depth by reciprocal (exact below 2^18)
	// --------------------------------------------------------------------
	logic             vld_s5, upper_s5;
	hts_item_t        item_s5;
	logic [LIN_W-1:0] lin_s5 [4];
	logic [LIN_W-1:0] quo_s5 [4];
	logic [15:0]      u_s5, v_s5;
	logic [37:0]      rprod [4];

	for (genvar c = 0; c < 4; c++) begin : g_recip
		assign rprod[c] = 38'(lin_s4[c]) * 38'(RECIP);

		always_ff @(posedge clk) begin
			if (en_up) begin
				lin_s5[c] <= lin_s4[c];
				quo_s5[c] <= 18'(rprod[c] >> RS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en_up) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			item_s5  <= item_s4;
			u_s5     <= u_s4;
			v_s5     <= v_s4;
			upper_s5 <= upper_s4;
		end
	end

	// --------------------------------------------------------------------
	// stage 6: memory stage; corner addresses reduced on entry, a query
	// reads one corner per cycle unless the output stalls, a load makes one write
	logic [AW-1:0]    maddr_s6 [4];
	logic             upper_s6;
	logic [15:0]      u_s6, v_s6;
	logic [LIN_W-1:0] modv [4];

	for (genvar c = 0; c < 4; c++) begin : g_mod
		assign modv[c] = lin_s5[c] - 18'(39'(quo_s5[c]) * MAXV);

		always_ff @(posedge clk) begin
			if (en_up) maddr_s6[c] <= AW'(21'(modv[c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (en_dn) begin
			if (en_up) begin
				vld_s6 <= vld_s5;
				cnt_q  <= 2'd0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			item_s6  <= item_s5;
			u_s6     <= u_s5;
			v_s6     <= v_s5;
			upper_s6 <= upper_s5;
		end
	end

	logic          wr_ok;
	logic [AW-1:0] waddr;
	assign wr_ok = 21'(item_s6.idx) < MAXV21;
	assign waddr = AW'(21'(item_s6.idx));

	// height store, one port, registered read data
	logic [7:0] mem [MAX_VERTICES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en_dn && vld_s6) begin
			if (item_s6.kind == KIND_QUERY) rdata_q <= mem[maddr_s6[cnt_q]];
			else if (wr_ok) mem[waddr] <= item_s6.val;
		end
	end

	// corners 0 to 2 are captured from the read register, steered by the registered corner index; corner 3 stays there
	logic       rd_vld_q;
	logic [1:0] rd_idx_q;
	logic [7:0] h0_q, h1_q, h2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			rd_idx_q <= 2'd0;
		end else if (en_dn) begin
			rd_vld_q <= vld_s6 && (item_s6.kind == KIND_QUERY);
			rd_idx_q <= cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en_dn && rd_vld_q) begin
			case (rd_idx_q)
				2'd0: h0_q <= rdata_q;
				2'd1: h1_q <= rdata_q;
				2'd2: h2_q <= rdata_q;
				default: ;
			endcase
		end
	end

	// --------------------------------------------------------------------
	// stage 7: query leaves the memory stage after its last read issued
	// --------------------------------------------------------------------
	logic        vld_s7, upper_s7;
	logic [15:0] u_s7, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en_dn) vld_s7 <= vld_s6 && (item_s6.kind == KIND_QUERY) && (cnt_q == 2'd3);
	end

	always_ff @(posedge clk) begin
		if (en_dn) begin
			u_s7     <= u_s6;
			v_s7     <= v_s6;
			upper_s7 <= upper_s6;
		end
	end

	// --------------------------------------------------------------------
	// stage 8: barycentric products; h3 is still in the read register
	// --------------------------------------------------------------------
	logic [7:0]         hb;
	logic signed [8:0]  d1, d2;
	logic signed [17:0] w1, w2;

	always_comb begin
		if (upper_s7) begin
			hb = rdata_q;
			d1 = $signed({1'b0, h2_q}) - $signed({1'b0, rdata_q});
			d2 = $signed({1'b0, h1_q}) - $signed({1'b0, rdata_q});
			w1 = $signed({1'b0, 17'h10000 - {1'b0, u_s7}});
			w2 = $signed({1'b0, 17'h10000 - {1'b0, v_s7}});
		end else begin
			hb = h0_q;
			d1 = $signed({1'b0, h1_q}) - $signed({1'b0, h0_q});
			d2 = $signed({1'b0, h2_q}) - $signed({1'b0, h0_q});
			w1 = $signed({2'b00, u_s7});
			w2 = $signed({2'b00, v_s7});
		end
	end

	logic               vld_s8;
	logic [7:0]         hb_s8;
	logic signed [26:0] p1_s8, p2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en_dn) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (en_dn) begin
			hb_s8 <= hb;
			p1_s8 <= d1 * w1;
			p2_s8 <= d2 * w2;
		end
	end

	// --------------------------------------------------------------------
	// stage 9: interpolated height in Q8.16, always within 0 .. 255 << 16
	// --------------------------------------------------------------------
	logic               vld_s9;
	logic [23:0]        h_s9;
	logic signed [27:0] hsum;

	assign hsum = $signed({4'b0000, hb_s8, 16'd0}) + 28'(p1_s8) + 28'(p2_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else if (en_dn) vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		if (en_dn) h_s9 <= hsum[23:0];
	end

	// --------------------------------------------------------------------
	// stage 10: vertical scale, floored to Q.8
	// --------------------------------------------------------------------
	logic [23:0] scl_s10;
	logic [39:0] sprod;

	assign sprod = 40'(h_s9) * 40'(scale_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s10 <= 1'b0;
		else if (en_dn) vld_s10 <= vld_s9;
	end

	always_ff @(posedge clk) begin
		if (en_dn) scl_s10 <= sprod[39:16];
	end

	// --------------------------------------------------------------------
	// output register: vertical offset added on the way in
	// --------------------------------------------------------------------
	logic signed [31:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en_dn && vld_s10) out_vld_q <= 1'b1;
		else if (out_ready) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en_dn && vld_s10) height_q <= $signed({8'd0, scl_s10}) + 32'($signed(offset_y_q));
	end

	assign out_valid      = out_vld_q;
	assign terrain_height = height_q;

endmodule

[hdl/hts_chk.sv]
`timescale 1ns / 1ps
// hts_chk: port-level checker of heightfield_triangle_sample_unit
// depends on hts_pkg and the top level's ports; bound to the top level below

module hts_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               kind,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] terrain_height
);
	import hts_pkg::*;

	// queries taken whose results are not yet delivered
	logic [7:0] pend_q;
	logic       q_acc, o_acc;

	assign q_acc = in_valid && in_ready && (kind == KIND_QUERY);
	assign o_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 8'd0;
		else pend_q <= pend_q + 8'(q_acc) - 8'(o_acc);
	end

	// a stalled result beat holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(terrain_height))
		else $error("result beat dropped or changed while stalled");

	// no result beat without an outstanding query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'd0)
		else $error("result beat without a query");

	// once the last outstanding result is taken, no new one shows up at once
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		o_acc && (pend_q == 8'd1) && !q_acc |=> !out_valid)
		else $error("result beat repeated");

	// reset leaves no result pending
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind heightfield_triangle_sample_unit hts_chk u_hts_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.kind           (kind),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.terrain_height (terrain_height)
);

[test/hts_checker.sv]
`timescale 1ns / 1ps
// hts_checker: watches the beat channels of the terrain height sampler, predicts heights
// depends on hts_pkg; instantiated by tb_heightfield_triangle_sample_unit

module hts_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               kind,
	input  logic [15:0]                        height_index,
	input  logic [7:0]                         height_value,
	input  logic signed [23:0]                 pos_x,
	input  logic signed [23:0]                 pos_z,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [31:0]                 terrain_height,
	output int                                 fail_count,
	output int                                 pending
);
	import hts_pkg::*;

	logic [7:0]  grid [0:65535];
	logic [8:0]  cols, rows;
	logic [15:0] csize;
	logic [23:0] hw, hh, sy;
	logic signed [23:0] oy;
	logic signed [31:0] height_fifo[$];

	// clamped cell coordinate in Q.16
	function automatic longint cell_pos(longint num, logic [8:0] verts);
		longint cap, q, dv;
		dv = (csize == 0) ? 1 : csize;
		cap = (verts >= 2) ? longint'(verts - 2) << 16 : 0;
		if (num <= 0)
			return 0;
		q = (num << 16) / dv;
		return (q > cap) ? cap : q;
	endfunction

	function automatic logic signed [31:0] sample_height(logic signed [23:0] px,
			logic signed [23:0] pz);
		longint cx, cz, u, v, h0, h1, h2, h3, h, base, sc;
		cx = cell_pos(longint'(hw) + px, cols);
		cz = cell_pos(longint'(hh) - pz, rows);
		u = cx & 16'hFFFF;
		v = cz & 16'hFFFF;
		base = (cz >> 16) * cols + (cx >> 16);
		h0 = grid[base[15:0]];
		h1 = grid[16'(base + 1)];
		h2 = grid[16'(base + cols)];
		h3 = grid[16'(base + cols + 1)];
		if (u + v > 65536)
			h = h3 * 65536 + (h2 - h3) * (65536 - u) + (h1 - h3) * (65536 - v);
		else
			h = h0 * 65536 + (h1 - h0) * u + (h2 - h0) * v;
		sc = (h * longint'(sy[15:0])) >>> 16;
		return 32'(sc + oy);
	endfunction

	task automatic report(string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols = RST_VERTEX_COLS; rows = RST_VERTEX_ROWS; csize = RST_CELL_SIZE;
			hw = RST_HALF_WIDTH; hh = RST_HALF_HEIGHT; sy = RST_SCALE_Y;
			oy = RST_OFFSET_Y;
			fail_count = 0;
			height_fifo.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VERTEX_COLS: cols = cfg_data[8:0];
					REG_VERTEX_ROWS: rows = cfg_data[8:0];
					REG_CELL_SIZE:   csize = cfg_data[15:0];
					REG_HALF_WIDTH:  hw = cfg_data;
					REG_HALF_HEIGHT: hh = cfg_data;
					REG_SCALE_Y:     sy = cfg_data[15:0];
					REG_OFFSET_Y:    oy = cfg_data;
					default: ;
				endcase
			end
			// result beat is compared against the oldest prediction
			if (out_valid && out_ready) begin
				if (height_fifo.size() == 0)
					report($sformatf("unexpected result %0d", terrain_height));
				else if (height_fifo[0] !== terrain_height)
					report($sformatf("terrain_height got %0d want %0d",
						terrain_height, height_fifo.pop_front()));
				else
					void'(height_fifo.pop_front());
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_LOAD)
					grid[height_index] = height_value;
				else
					height_fifo = {height_fifo, sample_height(pos_x, pos_z)};
			end
			pending = height_fifo.size();
		end
	end
endmodule

[test/tb_heightfield_triangle_sample_unit.sv]
`timescale 1ns / 1ps
// tb_heightfield_triangle_sample_unit: stimulus and verdict for the terrain height sampler
// depends on hts_pkg, heightfield_triangle_sample_unit and hts_checker

module tb_heightfield_triangle_sample_unit;
	import hts_pkg::*;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready, kind, out_valid, out_ready;
	logic [15:0] height_index;
	logic [7:0] height_value;
	logic signed [23:0] pos_x, pos_z;
	logic signed [31:0] terrain_height;
	int fail_count, pending;
	int cycles;
	bit hold_off;      // long receiver stall requested by stimulus

	heightfield_triangle_sample_unit u_top (.*);

	hts_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// global watchdog; the slowest run is well under this
	always @(posedge clk) begin
		cycles++;
		if (cycles > 900000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// random gaps, mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls plus one long hold-off when asked
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
				@(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// one beat, held until accepted; optional gap before it
	task automatic send(logic k, logic [15:0] idx, logic [7:0] val,
			logic signed [23:0] px, logic signed [23:0] pz, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k; height_index <= idx; height_value <= val;
		pos_x <= px; pos_z <= pz;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic load(logic [15:0] idx, logic [7:0] val, bit gaps);
		send(KIND_LOAD, idx, val, 24'($urandom), 24'($urandom), gaps);
	endtask

	task automatic query(logic signed [23:0] px, logic signed [23:0] pz, bit gaps);
		send(KIND_QUERY, 16'($urandom), 8'($urandom), px, pz, gaps);
	endtask

	// wait until all results are back, then drain the load tail
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1; cfg_index <= r; cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// fill every vertex of a cols x rows grid with random heights
	task automatic fill_grid(int c, int r, bit gaps);
		for (int i = 0; i < c * r; i++)
			load(16'(i), 8'($urandom), gaps);
	endtask

	// query anywhere: the clamp keeps corners inside the written grid
	function automatic logic signed [23:0] rand_pos();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 24'sh7FFFFF;
		if (r == 1)
			return 24'sh800000;
		if (r < 5)
			return 24'($urandom);
		return 24'($signed($urandom_range(0, 8192)) - 4096);
	endfunction

	task automatic setup(int c, int r, logic [15:0] cs, logic [23:0] hwv,
			logic [23:0] hhv, logic [15:0] sy, logic [23:0] oy);
		write_reg(REG_VERTEX_COLS, 24'(c));
		write_reg(REG_VERTEX_ROWS, 24'(r));
		write_reg(REG_CELL_SIZE, 24'(cs));
		write_reg(REG_HALF_WIDTH, hwv);
		write_reg(REG_HALF_HEIGHT, hhv);
		write_reg(REG_SCALE_Y, 24'(sy));
		write_reg(REG_OFFSET_Y, oy);
	endtask

	initial begin
		cycles = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; kind = KIND_LOAD; height_index = '0; height_value = '0;
		pos_x = '0; pos_z = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: 2x2 grid, unit cells, extremes of heights and positions
		setup(2, 2, 16'd256, 24'd128, 24'd128, 16'hFFFF, 24'h800000);
		load(16'd0, 8'd0, 0); load(16'd1, 8'd255, 0);
		load(16'd2, 8'd255, 0); load(16'd3, 8'd0, 0);
		load(16'hFFFF, 8'hAA, 0);   // top address, beyond grid, harmless
		query(24'sd0, 24'sd0, 0);           // center: diagonal tie
		query(24'sd127, 24'sd0, 0);         // upper triangle
		query(-24'sd128, 24'sd128, 0);      // origin corner
		query(24'sh7FFFFF, 24'sh800000, 0); // clamp high
		query(24'sh800000, 24'sh7FFFFF, 0); // negative numerator
		query(24'sd64, -24'sd64, 0);        // u + v above one, upper triangle
		settle();
		// zero cell size, too few vertices, zero scale, max offset
		setup(0, 1, 16'd0, 24'hFFFFFF, 24'd0, 16'd0, 24'h7FFFFF);
		query(24'sd5, 24'sd5, 0);
		query(24'sh7FFFFF, -24'sd1, 0);
		settle();
		setup(1, 0, 16'hFFFF, 24'd0, 24'hFFFFFF, 16'd256, 24'h000100);
		query(24'sd1000, 24'sd0, 0);
		query(24'sh800000, 24'sh800000, 0);
		settle();

		// random phases; the last uses a 256 x 2 grid
		for (int ph = 0; ph < 5; ph++) begin
			int c, r;
			c = (ph == 4) ? 256 : $urandom_range(2, 9);
			r = (ph == 4) ? 2 : $urandom_range(2, 9);
			setup(c, r, 16'($urandom_range(1, 1024)), 24'($urandom_range(0, 4096)),
				24'($urandom_range(0, 4096)), 16'($urandom), 24'($urandom));
			fill_grid(c, r, 1);
			if (ph == 2)
				hold_off = 1'b1;
			for (int k = 0; k < 35; k++) begin
				if ($urandom_range(0, 4) == 0)
					load(16'($urandom_range(0, c * r - 1)), 8'($urandom), 1);
				else
					query(rand_pos(), rand_pos(), (ph != 1));
			end
			settle();
		end
		// same 256 x 2 grid with max extents, cell size, scale and offset
		setup(256, 2, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'h7FFFFF);
		for (int k = 0; k < 30; k++)
			query(rand_pos(), rand_pos(), 1);
		settle();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[files.f]
hdl/hts_pkg.sv
hdl/heightfield_triangle_sample_unit.sv
hdl/hts_chk.sv
test/hts_checker.sv
test/tb_heightfield_triangle_sample_unit.sv
